// ===== src/ulcs_pkg.sv =====
package ulcs_pkg;

    // Link phases, encoded as reported on the link_state output.
    typedef enum logic [1:0] {
        PH_CONNECTING = 2'd0,
        PH_CHECK_CFG  = 2'd1,
        PH_CONNECTED  = 2'd2,
        PH_RECONNECT  = 2'd3
    } t_phase;

    // Event codes carried by the cmd field.
    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_BUSY       = 2'd1,
        CMD_STORAGE_DC = 2'd2,
        CMD_FORCED_DC  = 2'd3
    } t_cmd;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_BUSY_TICKS    = 2'd0;
    localparam logic [1:0] REG_CONNECT_DELAY = 2'd1;
    localparam logic [1:0] REG_AUTO_RUN      = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] BUSY_TICKS_RST    = 8'd33;
    localparam logic [7:0] CONNECT_DELAY_RST = 8'd11;

    // One result transaction.
    typedef struct packed {
        logic [1:0] link_state;
        logic       link_busy;
        logic       connect_line;
        logic       media_ready;
        logic       start_once_pulse;
        logic       transfer_reset_pulse;
        logic       target_run_pulse;
    } t_result;

endpackage

// ===== src/ulcs_core.sv =====
module ulcs_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_cmd,
    input  logic                i_host_configured,
    input  logic [7:0]          i_busy_ticks,
    input  logic [7:0]          i_connect_delay_ticks,
    input  logic                i_auto_target_run,
    output ulcs_pkg::t_result   o_result
);
    import ulcs_pkg::*;

    t_phase     r_phase,      n_phase;
    logic       r_busy,       n_busy;
    logic [7:0] r_busy_cnt,   n_busy_cnt;
    logic [7:0] r_phase_cnt,  n_phase_cnt;
    logic       r_started,    n_started;
    logic       r_connect,    n_connect;
    logic       r_ready,      n_ready;

    logic       start_p;
    logic       xfer_p;
    logic       run_p;
    logic [7:0] busy_dec;
    logic [7:0] phase_dec;
    t_cmd       cmd;

    assign cmd       = t_cmd'(i_cmd);
    assign busy_dec  = (r_busy_cnt != 8'd0) ? r_busy_cnt - 8'd1 : 8'd0;
    assign phase_dec = (r_phase_cnt != 8'd0) ? r_phase_cnt - 8'd1 : 8'd0;

    // Next state for one event.
    always_comb begin
        n_phase     = r_phase;
        n_busy      = r_busy;
        n_busy_cnt  = r_busy_cnt;
        n_phase_cnt = r_phase_cnt;
        n_started   = r_started;
        n_connect   = r_connect;
        n_ready     = r_ready;
        case (cmd)
            CMD_BUSY: begin
                n_busy_cnt = i_busy_ticks;
                n_busy     = 1'b1;
            end
            CMD_STORAGE_DC: begin
                n_busy      = 1'b0;
                n_phase_cnt = i_connect_delay_ticks;
                n_phase     = PH_RECONNECT;
            end
            CMD_FORCED_DC: begin
                n_busy      = 1'b0;
                n_phase_cnt = 8'd0;
                n_phase     = PH_RECONNECT;
            end
            default: begin
                // Slow tick: busy countdown runs first, then the phase logic.
                if (r_busy) begin
                    n_busy_cnt = busy_dec;
                    if (busy_dec == 8'd0) begin
                        n_busy = 1'b0;
                    end
                end
                case (r_phase)
                    PH_RECONNECT: begin
                        if (!n_busy) begin
                            n_phase_cnt = phase_dec;
                            if (phase_dec == 8'd0) begin
                                n_phase     = PH_CONNECTING;
                                n_phase_cnt = i_busy_ticks;
                                n_ready     = 1'b0;
                            end
                        end
                    end
                    PH_CONNECTING: begin
                        n_phase_cnt = phase_dec;
                        if (phase_dec == 8'd0) begin
                            n_connect = 1'b1;
                            n_phase   = PH_CHECK_CFG;
                        end
                    end
                    PH_CHECK_CFG: begin
                        if (i_host_configured) begin
                            n_started = 1'b1;
                            n_phase   = PH_CONNECTED;
                            n_ready   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    // Pulses for one event.
    always_comb begin
        start_p = 1'b0;
        xfer_p  = 1'b0;
        run_p   = 1'b0;
        case (cmd)
            CMD_STORAGE_DC: begin
                run_p = i_auto_target_run;
            end
            CMD_TICK: begin
                if (r_phase == PH_CHECK_CFG && i_host_configured) begin
                    xfer_p  = 1'b1;
                    start_p = !r_started;
                end
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after the event.
    always_comb begin
        o_result.link_state           = n_phase;
        o_result.link_busy            = n_busy;
        o_result.connect_line         = n_connect;
        o_result.media_ready          = n_ready;
        o_result.start_once_pulse     = start_p;
        o_result.transfer_reset_pulse = xfer_p;
        o_result.target_run_pulse     = run_p;
    end

    // State registers advance only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CONNECTING;
            r_busy      <= 1'b0;
            r_busy_cnt  <= 8'd0;
            r_phase_cnt <= CONNECT_DELAY_RST;
            r_started   <= 1'b0;
            r_connect   <= 1'b0;
            r_ready     <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_busy      <= n_busy;
            r_busy_cnt  <= n_busy_cnt;
            r_phase_cnt <= n_phase_cnt;
            r_started   <= n_started;
            r_connect   <= n_connect;
            r_ready     <= n_ready;
        end
    end

endmodule

// ===== src/usb_link_connect_sequencer.sv =====
// USB link connect sequencer. Each input transaction is one event (slow tick,
// busy mark, storage disconnect, forced disconnect) and produces exactly one
// result transaction carrying the link phase, busy flag, connect and media
// ready levels, and the start-once, transfer-reset and target-run pulses.
// The block takes one event per clock cycle unless o_stall is high. Each
// result is registered in the output register, or in the one-entry skid
// stage behind it while the output is stalled, so one further event is
// taken meanwhile; o_stall rises only when both are full. Configuration goes
// through the APB port (busy_ticks at 0x0, connect_delay_ticks at 0x4,
// auto_target_run at 0x8) and is to be written only while the block is idle.
module usb_link_connect_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Event channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_host_configured,
    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_link_state,
    output logic        o_link_busy,
    output logic        o_connect_line,
    output logic        o_media_ready,
    output logic        o_start_once_pulse,
    output logic        o_transfer_reset_pulse,
    output logic        o_target_run_pulse
);
    import ulcs_pkg::*;

    logic [7:0] r_busy_ticks;
    logic [7:0] r_connect_delay;
    logic       r_auto_run;

    logic       r_out_valid;
    t_result    r_out;
    logic       r_skid_valid;
    t_result    r_skid;

    logic       in_accept;
    logic       out_take;
    logic       cfg_write;
    logic [1:0] reg_index;
    t_result    result;

    // Configuration register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_ticks    <= BUSY_TICKS_RST;
            r_connect_delay <= CONNECT_DELAY_RST;
            r_auto_run      <= 1'b0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_BUSY_TICKS:    r_busy_ticks    <= pwdata[7:0];
                REG_CONNECT_DELAY: r_connect_delay <= pwdata[7:0];
                REG_AUTO_RUN:      r_auto_run      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_BUSY_TICKS:    prdata = {24'd0, r_busy_ticks};
            REG_CONNECT_DELAY: prdata = {24'd0, r_connect_delay};
            REG_AUTO_RUN:      prdata = {31'd0, r_auto_run};
            default:           prdata = 32'd0;
        endcase
    end

    // Handshakes.
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    ulcs_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_accept              (in_accept),
        .i_cmd                 (i_cmd),
        .i_host_configured     (i_host_configured),
        .i_busy_ticks          (r_busy_ticks),
        .i_connect_delay_ticks (r_connect_delay),
        .i_auto_target_run     (r_auto_run),
        .o_result              (result)
    );

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= result;
            end
        end else if (in_accept) begin
            r_skid <= result;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_link_state           = r_out.link_state;
    assign o_link_busy            = r_out.link_busy;
    assign o_connect_line         = r_out.connect_line;
    assign o_media_ready          = r_out.media_ready;
    assign o_start_once_pulse     = r_out.start_once_pulse;
    assign o_transfer_reset_pulse = r_out.transfer_reset_pulse;
    assign o_target_run_pulse     = r_out.target_run_pulse;

endmodule

// ===== tb/usb_link_connect_sequencer_test.sv =====
`timescale 1ns / 1ps

module usb_link_connect_sequencer_test;
    import ulcs_pkg::*;

    // Tracks the link sequencer state and holds the link reports still owed by the block.
    class link_scoreboard;
        logic [7:0] busy_ticks;
        logic [7:0] connect_delay;
        logic       auto_run;
        t_phase     phase;
        logic       busy_flag;
        logic [7:0] busy_left;
        logic [7:0] phase_left;
        logic       started;
        logic       connect_lvl;
        logic       ready_lvl;
        t_result    owed_reports[$];
        int unsigned mismatches;

        function new();
            busy_ticks    = BUSY_TICKS_RST;
            connect_delay = CONNECT_DELAY_RST;
            auto_run      = 1'b0;
            phase         = PH_CONNECTING;
            busy_flag     = 1'b0;
            busy_left     = 8'd0;
            phase_left    = CONNECT_DELAY_RST;
            started       = 1'b0;
            connect_lvl   = 1'b0;
            ready_lvl     = 1'b0;
            mismatches    = 0;
        endfunction

        // Countdowns hold at zero.
        function logic [7:0] count_down(logic [7:0] v);
            return (v == 8'd0) ? 8'd0 : v - 8'd1;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] value);
            case (idx)
                REG_BUSY_TICKS:    busy_ticks = value;
                REG_CONNECT_DELAY: connect_delay = value;
                REG_AUTO_RUN:      auto_run = value[0];
                default: ;
            endcase
        endfunction

        // Applies one accepted event and queues the link report it must produce.
        function void note_event(t_cmd cmd, logic host_cfg);
            t_result r;
            logic    start_p;
            logic    xfer_p;
            logic    run_p;
            start_p = 1'b0;
            xfer_p  = 1'b0;
            run_p   = 1'b0;
            case (cmd)
                CMD_BUSY: begin
                    busy_left = busy_ticks;
                    busy_flag = 1'b1;
                end
                CMD_STORAGE_DC: begin
                    run_p      = auto_run;
                    busy_flag  = 1'b0;
                    phase_left = connect_delay;
                    phase      = PH_RECONNECT;
                end
                CMD_FORCED_DC: begin
                    busy_flag  = 1'b0;
                    phase_left = 8'd0;
                    phase      = PH_RECONNECT;
                end
                default: begin
                    if (busy_flag) begin
                        busy_left = count_down(busy_left);
                        if (busy_left == 8'd0) busy_flag = 1'b0;
                    end
                    case (phase)
                        PH_RECONNECT: begin
                            // The reconnect countdown is frozen while the link is busy.
                            if (!busy_flag) begin
                                phase_left = count_down(phase_left);
                                if (phase_left == 8'd0) begin
                                    phase      = PH_CONNECTING;
                                    phase_left = busy_ticks;
                                    ready_lvl  = 1'b0;
                                end
                            end
                        end
                        PH_CONNECTING: begin
                            phase_left = count_down(phase_left);
                            if (phase_left == 8'd0) begin
                                connect_lvl = 1'b1;
                                phase       = PH_CHECK_CFG;
                            end
                        end
                        PH_CHECK_CFG: begin
                            if (host_cfg) begin
                                if (!started) begin
                                    started = 1'b1;
                                    start_p = 1'b1;
                                end
                                phase     = PH_CONNECTED;
                                xfer_p    = 1'b1;
                                ready_lvl = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            r.link_state           = phase;
            r.link_busy            = busy_flag;
            r.connect_line         = connect_lvl;
            r.media_ready          = ready_lvl;
            r.start_once_pulse     = start_p;
            r.transfer_reset_pulse = xfer_p;
            r.target_run_pulse     = run_p;
            owed_reports.push_back(r);
        endfunction

        // Compares one accepted report with the oldest one owed.
        function void check_report(t_result got);
            t_result want;
            if (owed_reports.size() == 0) begin
                $error("unexpected link report %b", got);
                mismatches++;
                return;
            end
            want = owed_reports.pop_front();
            if (got.link_state !== want.link_state) begin
                $error("link_state: expected %0d, got %0d", want.link_state, got.link_state);
                mismatches++;
            end
            if (got.link_busy !== want.link_busy) begin
                $error("link_busy: expected %0d, got %0d", want.link_busy, got.link_busy);
                mismatches++;
            end
            if (got.connect_line !== want.connect_line) begin
                $error("connect_line: expected %0d, got %0d",
                       want.connect_line, got.connect_line);
                mismatches++;
            end
            if (got.media_ready !== want.media_ready) begin
                $error("media_ready: expected %0d, got %0d",
                       want.media_ready, got.media_ready);
                mismatches++;
            end
            if (got.start_once_pulse !== want.start_once_pulse) begin
                $error("start_once_pulse: expected %0d, got %0d",
                       want.start_once_pulse, got.start_once_pulse);
                mismatches++;
            end
            if (got.transfer_reset_pulse !== want.transfer_reset_pulse) begin
                $error("transfer_reset_pulse: expected %0d, got %0d",
                       want.transfer_reset_pulse, got.transfer_reset_pulse);
                mismatches++;
            end
            if (got.target_run_pulse !== want.target_run_pulse) begin
                $error("target_run_pulse: expected %0d, got %0d",
                       want.target_run_pulse, got.target_run_pulse);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_reports.size();
        endfunction
    endclass

    localparam int unsigned EVENTS_PER_SETTING = 160;
    localparam int unsigned SETTINGS_COUNT     = 9;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = CMD_TICK;
    logic        i_host_configured = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_link_state;
    logic        o_link_busy;
    logic        o_connect_line;
    logic        o_media_ready;
    logic        o_start_once_pulse;
    logic        o_transfer_reset_pulse;
    logic        o_target_run_pulse;

    // Cleared during the quiet stretch, where neither side idles.
    bit allow_idle = 1'b1;

    link_scoreboard link_sb = new();

    usb_link_connect_sequencer u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_cmd                  (i_cmd),
        .i_host_configured      (i_host_configured),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_link_state           (o_link_state),
        .o_link_busy            (o_link_busy),
        .o_connect_line         (o_connect_line),
        .o_media_ready          (o_media_ready),
        .o_start_once_pulse     (o_start_once_pulse),
        .o_transfer_reset_pulse (o_transfer_reset_pulse),
        .o_target_run_pulse     (o_target_run_pulse)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls at random outside the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= allow_idle && ($urandom_range(99) < 34);
        end
    end

    // Every result transaction taken off the output is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            link_sb.check_report({o_link_state, o_link_busy, o_connect_line, o_media_ready,
                                  o_start_once_pulse, o_transfer_reset_pulse,
                                  o_target_run_pulse});
        end
    end

    // Sends one event transaction, with a random gap ahead of it.
    task automatic send_event(input t_cmd cmd, input logic host_cfg);
        while (allow_idle && ($urandom_range(99) < 34)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_cmd             <= cmd;
        i_host_configured <= host_cfg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        link_sb.note_event(cmd, host_cfg);
    endtask

    // Holds the event side off until every owed report has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (link_sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        link_sb.set_register(idx, value);
    endtask

    task automatic load_setting(input logic [7:0] bt, input logic [7:0] delay,
                                input logic run);
        apb_write(REG_BUSY_TICKS, bt);
        apb_write(REG_CONNECT_DELAY, delay);
        apb_write(REG_AUTO_RUN, {7'd0, run});
    endtask

    // Mostly ticks, so that countdowns run out and the link cycles through its phases.
    function automatic t_cmd random_event();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 78) return CMD_TICK;
        if (r < 86) return CMD_BUSY;
        if (r < 93) return CMD_STORAGE_DC;
        return CMD_FORCED_DC;
    endfunction

    initial begin : stimulus
        int unsigned s;
        int unsigned n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first tick runs on the reset configuration; the rest use short countdowns.
        send_event(CMD_TICK, 1'b1);
        drain_results();
        load_setting(8'd2, 8'd0, 1'b1);
        send_event(CMD_BUSY, 1'b0);
        // Forced disconnect drops the busy mark and enters reconnect with nothing to wait.
        send_event(CMD_FORCED_DC, 1'b1);
        send_event(CMD_BUSY, 1'b1);
        // The reconnect countdown stays put while busy, then expires once idle.
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_TICK, 1'b1);
        // Checking configured waits for the host.
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_BUSY, 1'b0);
        // Storage disconnect with target run enabled, then a fresh connect.
        send_event(CMD_STORAGE_DC, 1'b0);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_FORCED_DC, 1'b0);
        send_event(CMD_STORAGE_DC, 1'b1);
        drain_results();

        // A zero busy count sets the flag for exactly one tick.
        load_setting(8'd0, 8'd0, 1'b0);
        send_event(CMD_BUSY, 1'b1);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_STORAGE_DC, 1'b0);
        send_event(CMD_TICK, 1'b1);

        // Random events under a series of settings, reset values and extremes first.
        for (s = 0; s < SETTINGS_COUNT; s++) begin
            drain_results();
            case (s)
                0: load_setting(BUSY_TICKS_RST, CONNECT_DELAY_RST, 1'b0);
                1: load_setting(8'd0, 8'd0, 1'b1);
                2: load_setting(8'd255, 8'd255, 1'b0);
                3: load_setting(8'd1, 8'd1, 1'b1);
                4: load_setting(8'd0, 8'd255, 1'b1);
                5: load_setting(8'd255, 8'd0, 1'b0);
                default: load_setting(8'($urandom_range(6)), 8'($urandom_range(6)),
                                      1'($urandom_range(1)));
            endcase
            allow_idle = (s != 6);
            for (n = 0; n < EVENTS_PER_SETTING; n++) begin
                send_event(random_event(), 1'($urandom_range(1)));
                if ($urandom_range(199) == 0) drain_results();
            end
        end
        allow_idle = 1'b1;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (link_sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ulcs_pkg.sv
src/ulcs_core.sv
src/usb_link_connect_sequencer.sv
tb/usb_link_connect_sequencer_test.sv
